[design/priority_ready_queue_scheduler_assert.svh]
// Assertion macros for the ready-queue scheduler checker.
// Included by the checker file; it depends on nothing else.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRQS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PRQS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/prqs_pkg.sv]
// Shared types and constants of the ready-queue scheduler.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package prqs_pkg;

  // Field widths
  localparam int ID_W          = 5;
  localparam int ACT_W         = 2;
  localparam int RDY_W         = 32;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_FIELDS_W  = 3 * ID_W + 3 + RDY_W;
  localparam int OUT_TDATA_W   = 56;

  // Operation codes carried on the input tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_SCHEDULE = 2'd2,
    ACT_NONE     = 2'd3
  } act_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCHED,
    ST_RM_LOOKUP,
    ST_RM_UNLINK
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle: latch fields, issue table reads
    logic rd_level; // read head and tail of the removed thread's level
    logic do_ins;   // link thread at tail of its level
    logic do_sch;   // pick head of highest ready level
    logic do_rm;    // unlink thread from its level
    logic finish;   // result is complete this cycle
  } prqs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pend;   // a finished result waits behind the output register
    act_e in_act; // operation code on the input port
  } prqs_sts_t;

endpackage

[design/prqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the scheduler's link tables.
`timescale 1ns / 1ps

module prqs_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/prqs_ctrl.sv]
// Controller state machine of the ready-queue scheduler.
// Depends on prqs_pkg; drives the datapath through prqs_cmd_t.
`timescale 1ns / 1ps

module prqs_ctrl import prqs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  prqs_sts_t sts_i,
  output prqs_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = !sts_i.pend;
        if (s_valid_i && !sts_i.pend) begin
          cmd_o.accept = 1'b1;
          case (sts_i.in_act)
            ACT_REMOVE:   state_d = ST_RM_LOOKUP;
            ACT_SCHEDULE: state_d = ST_SCHED;
            default:      state_d = ST_INSERT;
          endcase
        end
      end
      ST_INSERT: begin
        cmd_o.do_ins = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCHED: begin
        cmd_o.do_sch = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_RM_LOOKUP: begin
        cmd_o.rd_level = 1'b1;
        state_d        = ST_RM_UNLINK;
      end
      ST_RM_UNLINK: begin
        cmd_o.do_rm  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/prqs_dp.sv]
// Datapath of the ready-queue scheduler: ready bitmap, queued bits,
// link-table RAMs, running thread and output register. Uses prqs_pkg, prqs_ram.
`timescale 1ns / 1ps

module prqs_dp import prqs_pkg::*; #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int THREAD_SLOTS    = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  prqs_cmd_t              cmd_i,
  output prqs_sts_t              sts_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [ACT_W-1:0]       s_tuser_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  localparam int PA = $clog2(PRIORITY_LEVELS);
  localparam int TA = $clog2(THREAD_SLOTS);

  // Input fields
  logic [ID_W-1:0] in_tid, in_prio;

  // Latched item
  act_e            act_q;
  logic [ID_W-1:0] tid_q, prio_q;
  logic [PA-1:0]   pick_q;

  // Control state
  logic [PRIORITY_LEVELS-1:0] ready_q, ready_d;
  logic [THREAD_SLOTS-1:0]    queued_q, queued_d;
  logic [ID_W-1:0]            run_tid_q;
  logic                       run_valid_q;
  logic                       out_valid_q, pend_q;
  logic [OUT_FIELDS_W-1:0]    out_q, pend_data_q;

  // Lowest ready level
  logic [PRIORITY_LEVELS-1:0] iso;
  logic [PA-1:0]              low_idx;

  // Table ports
  logic            head_we, tail_we, next_we, prev_we, lvl_we;
  logic [PA-1:0]   head_waddr, tail_waddr, head_raddr, tail_raddr, lvl_wdata, lvl_rd;
  logic [TA-1:0]   next_waddr, prev_waddr, lvl_waddr, tid_raddr;
  logic [ID_W-1:0] head_wdata, tail_wdata, next_wdata, prev_wdata;
  logic [ID_W-1:0] head_rd, tail_rd, next_rd, prev_rd;
  logic            tbl_re;

  // Decisions
  logic [TA-1:0] tid_a;
  logic [PA-1:0] prio_a;
  logic          tid_ok, prio_ok, ins_ok, ins_rb, rm_ok, is_head, is_tail;
  logic          none, sch_sw, out_free;
  logic          r_sw, r_fv, r_nr;
  logic [ID_W-1:0] r_ft, r_tt, r_cp;
  logic [OUT_FIELDS_W-1:0] res;

  assign in_tid  = s_tdata_i[ID_W-1:0];
  assign in_prio = s_tdata_i[2*ID_W-1:ID_W];

  assign sts_o.pend   = pend_q;
  assign sts_o.in_act = act_e'(s_tuser_i);

  // Find lowest set bit: isolate it, then encode the one-hot word
  always_comb begin
    iso     = ready_q & (~ready_q + PRIORITY_LEVELS'(1));
    low_idx = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (iso[i]) begin
        low_idx = low_idx | PA'(i);
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q  <= act_e'(s_tuser_i);
      tid_q  <= in_tid;
      prio_q <= in_prio;
      pick_q <= low_idx;
    end
  end

  // Operation checks
  assign tid_a   = TA'(tid_q);
  assign prio_a  = PA'(prio_q);
  assign tid_ok  = 32'(tid_q) < THREAD_SLOTS;
  assign prio_ok = 32'(prio_q) < PRIORITY_LEVELS;
  assign ins_rb  = ready_q[prio_a];
  assign ins_ok  = cmd_i.do_ins && (act_q == ACT_INSERT) && tid_ok && prio_ok
                   && !queued_q[tid_a];
  assign rm_ok   = cmd_i.do_rm && tid_ok && queued_q[tid_a];
  assign is_head = (head_rd == tid_q);
  assign is_tail = (tail_rd == tid_q);

  // Read addresses: lowest ready level and item fields at accept, stored level during remove lookup
  assign tbl_re     = cmd_i.accept || cmd_i.rd_level;
  assign tid_raddr  = TA'(in_tid);
  assign head_raddr = cmd_i.accept ? low_idx : lvl_rd;
  assign tail_raddr = cmd_i.accept ? PA'(in_prio) : lvl_rd;

  // Table writes, bitmap and queued bits
  always_comb begin
    head_we    = 1'b0;
    head_waddr = prio_a;
    head_wdata = tid_q;
    tail_we    = 1'b0;
    tail_waddr = prio_a;
    tail_wdata = tid_q;
    next_we    = 1'b0;
    next_waddr = TA'(tail_rd);
    next_wdata = tid_q;
    prev_we    = 1'b0;
    prev_waddr = tid_a;
    prev_wdata = tail_rd;
    lvl_we     = 1'b0;
    lvl_waddr  = tid_a;
    lvl_wdata  = prio_a;
    ready_d    = ready_q;
    queued_d   = queued_q;
    if (ins_ok) begin
      // append at tail; a fresh level also gets its head
      tail_we          = 1'b1;
      lvl_we           = 1'b1;
      queued_d[tid_a]  = 1'b1;
      ready_d[prio_a]  = 1'b1;
      if (ins_rb) begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end else begin
        head_we = 1'b1;
      end
    end
    if (rm_ok) begin
      queued_d[tid_a] = 1'b0;
      if (is_head && is_tail) begin
        ready_d[lvl_rd] = 1'b0;
      end else if (is_head) begin
        head_we    = 1'b1;
        head_waddr = lvl_rd;
        head_wdata = next_rd;
      end else if (is_tail) begin
        tail_we    = 1'b1;
        tail_waddr = lvl_rd;
        tail_wdata = prev_rd;
      end else begin
        // bridge neighbors around the thread
        next_we    = 1'b1;
        next_waddr = TA'(prev_rd);
        next_wdata = next_rd;
        prev_we    = 1'b1;
        prev_waddr = TA'(next_rd);
        prev_wdata = prev_rd;
      end
    end
  end

  // Schedule decision and result fields
  always_comb begin
    none   = ~|ready_q;
    sch_sw = cmd_i.do_sch && !none && (!run_valid_q || (run_tid_q != head_rd));
    r_sw   = sch_sw;
    r_fv   = sch_sw && run_valid_q;
    r_ft   = (sch_sw && run_valid_q) ? run_tid_q : '0;
    r_tt   = (cmd_i.do_sch && !none) ? head_rd : '0;
    r_cp   = (cmd_i.do_sch && !none) ? ID_W'(pick_q) : '0;
    r_nr   = cmd_i.do_sch && none;
    res    = {RDY_W'(ready_d), r_nr, r_cp, r_tt, r_ft, r_fv, r_sw};
  end

  // Control registers
  assign out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= '0;
      queued_q    <= '0;
      run_tid_q   <= '0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      ready_q  <= ready_d;
      queued_q <= queued_d;
      if (sch_sw) begin
        run_tid_q   <= head_rd;
        run_valid_q <= 1'b1;
      end
      // output register with one waiting slot behind it
      if (cmd_i.finish) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_q <= 1'b1;
        end
      end else if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        pend_data_q <= res;
      end
    end else if (pend_q && out_free) begin
      out_q <= pend_data_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_q};

  // Link tables
  prqs_ram #(.WIDTH(ID_W), .DEPTH(PRIORITY_LEVELS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(tbl_re), .raddr_i(head_raddr), .rdata_o(head_rd)
  );

  prqs_ram #(.WIDTH(ID_W), .DEPTH(PRIORITY_LEVELS)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_waddr), .wdata_i(tail_wdata),
    .re_i(tbl_re), .raddr_i(tail_raddr), .rdata_o(tail_rd)
  );

  prqs_ram #(.WIDTH(ID_W), .DEPTH(THREAD_SLOTS)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .re_i(cmd_i.accept), .raddr_i(tid_raddr), .rdata_o(next_rd)
  );

  prqs_ram #(.WIDTH(ID_W), .DEPTH(THREAD_SLOTS)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .re_i(cmd_i.accept), .raddr_i(tid_raddr), .rdata_o(prev_rd)
  );

  prqs_ram #(.WIDTH(PA), .DEPTH(THREAD_SLOTS)) u_level (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(lvl_wdata),
    .re_i(cmd_i.accept), .raddr_i(tid_raddr), .rdata_o(lvl_rd)
  );

endmodule

[design/priority_ready_queue_scheduler.sv]
// Insert and no-op finish in ST_INSERT, schedule in ST_SCHED; remove goes through
// ST_RM_LOOKUP then ST_RM_UNLINK, for a dependent read of the thread's level and
// then of that level's head and tail in the registered-read link tables. Items are
// taken only in ST_IDLE, so each one finishes before the next; a result waiting at
// the output lets one more item in. Reset clears the bitmap, queued bits, running
// thread and handshake state at once; link tables are not cleared.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler import prqs_pkg::*; #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int THREAD_SLOTS    = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // thread_id[4:0], priority_level[9:5]
  input  logic [ACT_W-1:0]       s_axis_tuser,  // action[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // switch_now[0], from_valid[1],
                                                // old_thread[6:2], new_thread[11:7],
                                                // chosen_priority[16:12],
                                                // none_ready[17], ready_levels[49:18]
);

  prqs_cmd_t cmd;
  prqs_sts_t sts;

  prqs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  prqs_dp #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .THREAD_SLOTS   (THREAD_SLOTS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_o (m_axis_tdata)
  );

endmodule

[design/prqs_chk.sv]
// Port-level checker for the ready-queue scheduler, bound to the top level.
// Depends on priority_ready_queue_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "priority_ready_queue_scheduler_assert.svh"

module prqs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // A stalled result holds
  `PRQS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Each input transfer is followed by a busy cycle
  `PRQS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken on back-to-back cycles")

  // An empty bitmap reports no pick and no switch
  `PRQS_ASSERT_NOW(a_none_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[17], m_axis_tdata[16:0] == 17'd0 && m_axis_tdata[49:18] == 32'd0, "none_ready with pick")

  // A switch away from a running thread goes to another thread
  `PRQS_ASSERT_NOW(a_switch_differs, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0] && m_axis_tdata[6:2] != m_axis_tdata[11:7], "bad switch report")

endmodule

bind priority_ready_queue_scheduler prqs_chk u_prqs_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[dv/priority_ready_queue_scheduler_tb.sv]
// Self-checking testbench for the ready-queue scheduler: directed and random
// insert/remove/schedule traffic under varied stream backpressure.
// Depends on prqs_pkg and priority_ready_queue_scheduler only.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_tb import prqs_pkg::*; ();

  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int LONG_HOLD   = 300;   // receiver hold-off that fills the block

  // Result fields, switch_now in the lowest bit as on m_axis_tdata
  typedef struct packed {
    logic [RDY_W-1:0] ready_levels;
    logic             none_ready;
    logic [ID_W-1:0]  chosen_priority;
    logic [ID_W-1:0]  new_thread;
    logic [ID_W-1:0]  old_thread;
    logic             from_valid;
    logic             switch_now;
  } sched_result_t;

  // Ready-queue predictor and store of pending scheduler results
  class sched_scoreboard;
    logic [RDY_W-1:0] ready_bits;
    logic [ID_W-1:0]  head_of[32];
    logic [ID_W-1:0]  tail_of[32];
    logic [ID_W-1:0]  next_of[32];
    logic [ID_W-1:0]  prev_of[32];
    logic [ID_W-1:0]  level_of[32];
    bit               queued[32];
    logic [ID_W-1:0]  run_thread;
    bit               run_valid;
    sched_result_t    pending_q[$];
    int               n_checked;
    int               n_mismatch;
    int               n_switch;
    int               n_empty;

    function new();
      ready_bits = '0;
      foreach (queued[i]) begin
        head_of[i]  = '0;
        tail_of[i]  = '0;
        next_of[i]  = '0;
        prev_of[i]  = '0;
        level_of[i] = '0;
        queued[i]   = 1'b0;
      end
      run_thread = '0;
      run_valid  = 1'b0;
    endfunction

    // Apply one accepted item to the queues and record its result
    function void note_transfer(act_e op, logic [ID_W-1:0] tid, logic [ID_W-1:0] prio);
      sched_result_t    r;
      logic [ID_W-1:0]  lvl;
      logic [ID_W-1:0]  pick;
      logic [ID_W-1:0]  a;
      logic [ID_W-1:0]  b;
      r = '0;
      case (op)
        ACT_INSERT: if (!queued[tid]) begin
          // append at the tail, or open an empty level
          if (ready_bits[prio]) begin
            next_of[tail_of[prio]] = tid;
            prev_of[tid] = tail_of[prio];
            tail_of[prio] = tid;
          end else begin
            head_of[prio] = tid;
            tail_of[prio] = tid;
            ready_bits[prio] = 1'b1;
          end
          level_of[tid] = prio;
          queued[tid] = 1'b1;
        end
        ACT_REMOVE: if (queued[tid]) begin
          lvl = level_of[tid];
          if (head_of[lvl] == tid && tail_of[lvl] == tid) begin
            ready_bits[lvl] = 1'b0;
          end else if (head_of[lvl] == tid) begin
            head_of[lvl] = next_of[tid];
          end else if (tail_of[lvl] == tid) begin
            tail_of[lvl] = prev_of[tid];
          end else begin
            a = prev_of[tid];
            b = next_of[tid];
            next_of[a] = b;
            prev_of[b] = a;
          end
          queued[tid] = 1'b0;
        end
        ACT_SCHEDULE: begin
          if (ready_bits == '0) begin
            r.none_ready = 1'b1;
            n_empty++;
          end else begin
            // lowest set bit is the highest ready priority
            lvl = '0;
            while (lvl < 31 && !ready_bits[lvl]) lvl++;
            pick = head_of[lvl];
            r.new_thread = pick;
            r.chosen_priority = lvl;
            if (!run_valid || run_thread != pick) begin
              r.switch_now = 1'b1;
              r.from_valid = run_valid;
              r.old_thread = run_valid ? run_thread : '0;
              run_thread = pick;
              run_valid  = 1'b1;
              n_switch++;
            end
          end
        end
        default: ;
      endcase
      r.ready_levels = ready_bits;
      pending_q.push_back(r);
    endfunction

    function void flag(string msg);
      n_mismatch++;
      if (n_mismatch <= 10) $display("%s", msg);
    endfunction

    // Compare one output transfer against the oldest pending result
    function void check_transfer(logic [OUT_TDATA_W-1:0] data);
      sched_result_t got;
      sched_result_t want;
      got = data[OUT_FIELDS_W-1:0];
      n_checked++;
      if (pending_q.size() == 0) begin
        flag($sformatf("unexpected result %h with nothing pending", data));
        return;
      end
      want = pending_q.pop_front();
      if (got.switch_now !== want.switch_now || got.from_valid !== want.from_valid ||
          got.old_thread !== want.old_thread || got.new_thread !== want.new_thread ||
          got.chosen_priority !== want.chosen_priority ||
          got.none_ready !== want.none_ready || got.ready_levels !== want.ready_levels)
        flag($sformatf({"result %0d: expected sw=%0b fv=%0b from=%0d to=%0d prio=%0d ",
                        "none=%0b rdy=%h; got sw=%0b fv=%0b from=%0d to=%0d prio=%0d ",
                        "none=%0b rdy=%h"}, n_checked,
                       want.switch_now, want.from_valid, want.old_thread, want.new_thread,
                       want.chosen_priority, want.none_ready, want.ready_levels,
                       got.switch_now, got.from_valid, got.old_thread, got.new_thread,
                       got.chosen_priority, got.none_ready, got.ready_levels));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // thread_id[4:0], priority_level[9:5]
  logic [ACT_W-1:0]       s_axis_tuser = '0;  // action[1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // switch_now[0], from_valid[1],
                                              // old_thread[6:2], new_thread[11:7],
                                              // chosen_priority[16:12],
                                              // none_ready[17], ready_levels[49:18]

  sched_scoreboard sb = new();
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  int  n_sent = 0;
  int  focus_base = 0;

  priority_ready_queue_scheduler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: check results, stall at random or hold off on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_transfer(m_axis_tdata);
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one item after random idle cycles and hold it until the transfer
  task automatic send_item(act_e op, logic [ID_W-1:0] tid, logic [ID_W-1:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W - 2 * ID_W){1'b0}}, prio, tid};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_transfer(op, tid, prio);
    n_sent++;
  endtask

  // Stop offering until every pending result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  // Random traffic focused on a few threads and levels so queues grow deep
  task automatic run_phase(int send_idle, int recv_stall, int count, bit with_hold,
                           bit with_pause);
    int              pick;
    act_e            op;
    logic [ID_W-1:0] tid;
    logic [ID_W-1:0] prio;
    idle_pct   = send_idle;
    stall_pct  = recv_stall;
    focus_base = $urandom_range(24);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 4) hold_request = 1'b1;
      if (with_pause && i == count / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 40)      op = ACT_INSERT;
      else if (pick < 70) op = ACT_REMOVE;
      else if (pick < 96) op = ACT_SCHEDULE;
      else                op = ACT_NONE;
      tid  = ($urandom_range(99) < 70) ? ID_W'(focus_base + $urandom_range(7))
                                       : ID_W'($urandom_range(31));
      prio = $urandom_range(1) ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(31));
      send_item(op, tid, prio);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty schedule, ignored items, extremes, all unlink cases
    send_item(ACT_SCHEDULE, 5'd0, 5'd0);
    send_item(ACT_REMOVE, 5'd0, 5'd0);
    send_item(ACT_NONE, 5'd31, 5'd31);
    send_item(ACT_INSERT, 5'd31, 5'd31);
    send_item(ACT_INSERT, 5'd0, 5'd0);
    send_item(ACT_INSERT, 5'd5, 5'd0);
    send_item(ACT_INSERT, 5'd0, 5'd7);
    send_item(ACT_SCHEDULE, 5'd17, 5'd21);
    send_item(ACT_SCHEDULE, 5'd0, 5'd0);
    send_item(ACT_INSERT, 5'd3, 5'd0);
    send_item(ACT_REMOVE, 5'd5, 5'd0);
    send_item(ACT_REMOVE, 5'd3, 5'd0);
    send_item(ACT_SCHEDULE, 5'd0, 5'd0);
    send_item(ACT_REMOVE, 5'd0, 5'd0);
    send_item(ACT_SCHEDULE, 5'd0, 5'd0);
    send_item(ACT_INSERT, 5'd0, 5'd0);
    send_item(ACT_SCHEDULE, 5'd0, 5'd0);
    send_item(ACT_REMOVE, 5'd0, 5'd0);
    send_item(ACT_INSERT, 5'd7, 5'd4);
    send_item(ACT_INSERT, 5'd9, 5'd4);
    send_item(ACT_REMOVE, 5'd7, 5'd4);
    send_item(ACT_SCHEDULE, 5'd0, 5'd0);
    send_item(ACT_REMOVE, 5'd31, 5'd0);
    send_item(ACT_REMOVE, 5'd9, 5'd0);
    send_item(ACT_SCHEDULE, 5'd0, 5'd0);

    // Random phases under different idle and stall mixes
    run_phase(0, 0, 400, 1'b1, 1'b0);
    run_phase(88, 0, 400, 1'b0, 1'b1);
    run_phase(0, 88, 400, 1'b0, 1'b0);
    run_phase(28, 28, 450, 1'b0, 1'b0);

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d items over four backpressure mixes; checked %0d results",
             n_sent, sb.n_checked);
    $display("  including %0d thread switches and %0d empty-bitmap schedules",
             sb.n_switch, sb.n_empty);
    if (sb.n_mismatch == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_mismatch, sb.pending_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
